// ===== design/fdp_pkg.sv =====
// shared types and constants for the flip-dot frame packetizer
// used by fdp_ctrl, fdp_datapath and flip_dot_frame_packetizer; no dependencies
package fdp_pkg;

    // frame geometry
    localparam int WIDTH      = 28;
    localparam int HEIGHT     = 13;
    localparam int ROW_BITS   = 28;
    localparam int BAND_ROWS  = 5;
    localparam int HDR_BYTES  = 7;
    localparam int BHDR_BYTES = 6;

    // index counter wide enough for the header and for every column
    localparam int IDX_W = (WIDTH > 8) ? $clog2(WIDTH) : 3;

    // packet byte codes
    localparam logic [7:0] BYTE_FRAME = 8'hff;
    localparam logic [7:0] BYTE_ESC   = 8'hfe;
    localparam logic [7:0] BYTE_ESC1  = 8'h01;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_CMD   = 8'ha2;
    localparam logic [7:0] LBL_WIDTH  = 8'hd0;
    localparam logic [7:0] LBL_HEIGHT = 8'hd1;
    localparam logic [7:0] LBL_XOFS   = 8'hd2;
    localparam logic [7:0] LBL_YOFS   = 8'hd3;
    localparam logic [7:0] LBL_FONT   = 8'hd4;
    localparam logic [7:0] BYTE_FONT  = 8'h77;
    localparam logic [7:0] COL_BIAS   = 8'd32;

    // register index of sign_address
    localparam logic REG_SIGN_ADDR = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_BHDR,
        S_COL,
        S_CK,
        S_CKX,
        S_STOP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic   take;
        logic   emit;
        logic   sec_end;
        state_t sel;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic first_now;
        logic band_now;
        logic band_reg;
        logic last_reg;
        logic hdr_end;
        logic bhdr_end;
        logic col_end;
        logic ck_esc;
    } dp_stat_t;

endpackage

// ===== design/fdp_ctrl.sv =====
// sequencer state machine for the packetizer: walks header, band and checksum sections
// depends on fdp_pkg
module fdp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              row_valid,
    output logic              row_ready,
    input  fdp_pkg::dp_stat_t stat,
    output fdp_pkg::ctrl_cmd_t cmd
);
    import fdp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (row_valid)
                begin
                    if (stat.first_now)
                        state_next = S_HDR;
                    else if (stat.band_now)
                        state_next = S_BHDR;
                end
            end
            S_HDR:
            begin
                if (stat.out_free && stat.hdr_end)
                    state_next = stat.band_reg ? S_BHDR : S_IDLE;
            end
            S_BHDR:
            begin
                if (stat.out_free && stat.bhdr_end)
                    state_next = S_COL;
            end
            S_COL:
            begin
                if (stat.out_free && stat.col_end)
                    state_next = stat.last_reg ? S_CK : S_IDLE;
            end
            S_CK:
            begin
                if (stat.out_free)
                    state_next = stat.ck_esc ? S_CKX : S_STOP;
            end
            S_CKX:
            begin
                if (stat.out_free)
                    state_next = S_STOP;
            end
            S_STOP:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        row_ready   = 1'b0;
        cmd.take    = 1'b0;
        cmd.emit    = 1'b0;
        cmd.sec_end = 1'b0;
        cmd.sel     = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                row_ready = 1'b1;
                cmd.take  = row_valid;
            end
            S_HDR:
            begin
                cmd.emit    = stat.out_free;
                cmd.sec_end = stat.hdr_end;
            end
            S_BHDR:
            begin
                cmd.emit    = stat.out_free;
                cmd.sec_end = stat.bhdr_end;
            end
            S_COL:
            begin
                cmd.emit    = stat.out_free;
                cmd.sec_end = stat.col_end;
            end
            S_CK, S_CKX, S_STOP:
            begin
                cmd.emit    = stat.out_free;
                cmd.sec_end = 1'b1;
            end
            default:
            begin
                row_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/fdp_datapath.sv =====
// packetizer datapath: band columns, row and band counters, checksum and output register
// depends on fdp_pkg
module fdp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         sign_address,
    input  logic [27:0]        row_bits,
    input  fdp_pkg::ctrl_cmd_t cmd,
    output fdp_pkg::dp_stat_t  stat,
    output logic [7:0]         line_byte,
    output logic               packet_end,
    output logic               out_valid,
    input  logic               out_ready
);
    import fdp_pkg::*;

    logic [4:0]       col_reg [WIDTH];
    logic [4:0]       col_next [WIDTH];
    logic [7:0]       row_reg, row_next;
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       start_reg, start_next;
    logic [7:0]       ofs_reg, ofs_next;
    logic             band_reg, band_next;
    logic             last_reg, last_next;
    logic [7:0]       sum_reg, sum_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       byte_reg, byte_next;
    logic             end_reg, end_next;
    logic             valid_reg, valid_next;

    logic       last_now;
    logic       band_now;
    logic [7:0] emit_byte;
    logic       emit_content;
    logic [4:0] col_sel;

    assign last_now = (row_reg >= 8'(HEIGHT - 1));
    assign band_now = (phase_reg == 3'(BAND_ROWS - 1)) || last_now;
    assign col_sel  = col_reg[idx_reg];

    // band column update on a row transfer
    always_comb
    begin
        for (int x = 0; x < WIDTH; x++)
        begin
            col_next[x] = col_reg[x];
            if (cmd.take)
            begin
                col_next[x] = (phase_reg == 3'd0) ? 5'd0 : col_reg[x];
                if (x < ROW_BITS)
                begin
                    if (row_bits[x])
                        col_next[x] = col_next[x] | (5'd1 << phase_reg);
                end
            end
        end
    end

    // row, band and flag bookkeeping
    always_comb
    begin
        row_next   = row_reg;
        phase_next = phase_reg;
        start_next = start_reg;
        ofs_next   = ofs_reg;
        band_next  = band_reg;
        last_next  = last_reg;
        if (cmd.take)
        begin
            ofs_next  = start_reg + 8'd4;
            band_next = band_now;
            last_next = last_now;
            if (last_now)
            begin
                row_next   = 8'd0;
                phase_next = 3'd0;
                start_next = 8'd0;
            end
            else
            begin
                row_next = row_reg + 8'd1;
                if (phase_reg == 3'(BAND_ROWS - 1))
                begin
                    phase_next = 3'd0;
                    start_next = row_reg + 8'd1;
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                end
            end
        end
    end

    // byte source selection
    always_comb
    begin
        emit_byte    = BYTE_ZERO;
        emit_content = 1'b0;
        case (cmd.sel)
            S_HDR:
            begin
                emit_content = (idx_reg != '0);
                case (idx_reg)
                    IDX_W'(0): emit_byte = BYTE_FRAME;
                    IDX_W'(1): emit_byte = sign_address;
                    IDX_W'(2): emit_byte = BYTE_CMD;
                    IDX_W'(3): emit_byte = LBL_WIDTH;
                    IDX_W'(4): emit_byte = 8'(WIDTH);
                    IDX_W'(5): emit_byte = LBL_HEIGHT;
                    default:   emit_byte = 8'(HEIGHT);
                endcase
            end
            S_BHDR:
            begin
                emit_content = 1'b1;
                case (idx_reg)
                    IDX_W'(0): emit_byte = LBL_XOFS;
                    IDX_W'(1): emit_byte = BYTE_ZERO;
                    IDX_W'(2): emit_byte = LBL_YOFS;
                    IDX_W'(3): emit_byte = ofs_reg;
                    IDX_W'(4): emit_byte = LBL_FONT;
                    default:   emit_byte = BYTE_FONT;
                endcase
            end
            S_COL:
            begin
                emit_content = 1'b1;
                emit_byte    = COL_BIAS + {3'd0, col_sel};
            end
            S_CK:
            begin
                emit_byte = stat.ck_esc ? BYTE_ESC : sum_reg;
            end
            S_CKX:
            begin
                emit_byte = (sum_reg == BYTE_FRAME) ? BYTE_ESC1 : BYTE_ZERO;
            end
            S_STOP:
            begin
                emit_byte = BYTE_FRAME;
            end
            default:
            begin
                emit_byte = BYTE_ZERO;
            end
        endcase
    end

    // checksum, index and output register
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.take && (row_reg == 8'd0))
            sum_next = 8'd0;
        else if (cmd.emit && emit_content)
            sum_next = sum_reg + emit_byte;

        idx_next = idx_reg;
        if (cmd.emit)
            idx_next = cmd.sec_end ? '0 : idx_reg + IDX_W'(1);

        byte_next  = byte_reg;
        end_next   = end_reg;
        valid_next = valid_reg && !out_ready;
        if (cmd.emit)
        begin
            byte_next  = emit_byte;
            end_next   = (cmd.sel == S_STOP);
            valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 8'd0;
            phase_reg <= 3'd0;
            start_reg <= 8'd0;
            band_reg  <= 1'b0;
            last_reg  <= 1'b0;
            sum_reg   <= 8'd0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            for (int x = 0; x < WIDTH; x++)
            begin
                col_reg[x] <= 5'd0;
            end
        end
        else
        begin
            row_reg   <= row_next;
            phase_reg <= phase_next;
            start_reg <= start_next;
            band_reg  <= band_next;
            last_reg  <= last_next;
            sum_reg   <= sum_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            for (int x = 0; x < WIDTH; x++)
            begin
                col_reg[x] <= col_next[x];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ofs_reg  <= ofs_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    // status towards the controller
    always_comb
    begin
        stat.out_free  = !valid_reg || out_ready;
        stat.first_now = (row_reg == 8'd0);
        stat.band_now  = band_now;
        stat.band_reg  = band_reg;
        stat.last_reg  = last_reg;
        stat.hdr_end   = (idx_reg == IDX_W'(HDR_BYTES - 1));
        stat.bhdr_end  = (idx_reg == IDX_W'(BHDR_BYTES - 1));
        stat.col_end   = (idx_reg == IDX_W'(WIDTH - 1));
        stat.ck_esc    = (sum_reg == BYTE_FRAME) || (sum_reg == BYTE_ESC);
    end

    assign line_byte  = byte_reg;
    assign packet_end = end_reg;
    assign out_valid  = valid_reg;

endmodule

// ===== design/flip_dot_frame_packetizer.sv =====
// a row's first packet byte reaches m_tdata through the state register and then the output register
// throughput: one packet byte per cycle while m_tready is high; a row emits the bytes of its sections
// (7 header, 6 + WIDTH per band, 2 or 3 checksum/stop)
// rows that emit nothing only update the bands and counters; the single output register
// lets a row enter while the last byte of the previous one waits
// reset: asynchronous active low, clears row count, checksum, bands and sign_address
module flip_dot_frame_packetizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [27:0] row_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] line_byte
    output logic        m_tlast    // packet_end
);
    import fdp_pkg::*;

    logic       [7:0] sign_addr_reg;
    ctrl_cmd_t        cmd;
    dp_stat_t         stat;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_addr_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_SIGN_ADDR))
        begin
            sign_addr_reg <= pwdata[7:0];
        end
    end

    // register read back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIGN_ADDR) ? {24'd0, sign_addr_reg} : 32'd0;

    fdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (s_tvalid),
        .row_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fdp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sign_address (sign_addr_reg),
        .row_bits     (s_tdata[27:0]),
        .cmd          (cmd),
        .stat         (stat),
        .line_byte    (m_tdata),
        .packet_end   (m_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

`ifndef SYNTHESIS
    // the stop byte is always the frame byte
    a_stop_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == BYTE_FRAME)
        else $error("stop byte is not the frame byte");

    // a new byte never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && m_tvalid && !m_tready))
        else $error("output byte overwritten while stalled");

    // a row that opens a packet or closes a band keeps the input closed next cycle
    a_busy_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (stat.first_now || stat.band_now) |=> !s_tready)
        else $error("input reopened while a section is pending");
`endif

endmodule
